>>> design/rau_pkg.sv
// Shared types and constants of the rational arithmetic unit.
package rau_pkg;

  localparam int OPERAND_WIDTH = 16;
  localparam int OPR_W         = OPERAND_WIDTH + 1;
  localparam int PROD_W        = 2 * OPR_W;
  localparam int MAG_W         = 2 * OPERAND_WIDTH;
  localparam int CNT_W         = $clog2(MAG_W);
  localparam int RES_NUM_W     = 32;
  localparam int RES_DEN_W     = 31;

  localparam logic [2:0] CMD_ADD = 3'd0;
  localparam logic [2:0] CMD_SUB = 3'd1;
  localparam logic [2:0] CMD_MUL = 3'd2;
  localparam logic [2:0] CMD_DIV = 3'd3;
  localparam logic [2:0] CMD_LT  = 3'd4;
  localparam logic [2:0] CMD_EQ  = 3'd5;

  typedef struct packed {
    logic [2:0]                       command;
    logic signed [OPERAND_WIDTH-1:0]  a_num;
    logic signed [OPERAND_WIDTH-1:0]  a_den;
    logic signed [OPERAND_WIDTH-1:0]  b_num;
    logic signed [OPERAND_WIDTH-1:0]  b_den;
  } in_item_t;

  typedef struct packed {
    logic signed [RES_NUM_W-1:0] res_num;
    logic [RES_DEN_W-1:0]        res_den;
    logic                        flag;
    logic                        status;
  } out_item_t;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_RED_A,
    DP_RED_B,
    DP_RED_R,
    DP_SAVE_A,
    DP_SAVE_B,
    DP_MUL0,
    DP_MUL1,
    DP_MUL2,
    DP_WR_RED,
    DP_WR_FLAG,
    DP_WR_ERR
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_ctrl_t;

  typedef struct packed {
    logic       den_zero;
    logic       bnum_zero;
    logic       red_done;
    logic       out_free;
    logic [2:0] cmd;
  } dp_stat_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_RED_A,
    ST_WAIT_A,
    ST_RED_B,
    ST_WAIT_B,
    ST_MUL0,
    ST_MUL1,
    ST_MUL2,
    ST_DECIDE,
    ST_RED_R,
    ST_WAIT_R,
    ST_OUT_RED,
    ST_OUT_FLAG,
    ST_OUT_ERR
  } ctrl_state_t;

  typedef enum logic [1:0] {
    RP_IDLE,
    RP_GCD,
    RP_DIV
  } red_phase_t;

endpackage

>>> design/rau_reduce.sv
// Fraction reduction unit: binary gcd followed by two restoring dividers.
module rau_reduce (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic                      neg_i,
  input  logic [rau_pkg::MAG_W-1:0] num_i,
  input  logic [rau_pkg::MAG_W-1:0] den_i,
  output logic                      done,
  output logic                      neg_o,
  output logic [rau_pkg::MAG_W-1:0] quo_num,
  output logic [rau_pkg::MAG_W-1:0] quo_den
);
  import rau_pkg::*;

  red_phase_t       phase_r, phase_nxt;
  logic             done_r, done_nxt;
  logic             neg_r, neg_nxt;
  logic [MAG_W-1:0] u_r, u_nxt, v_r, v_nxt;
  logic [MAG_W-1:0] ns_r, ns_nxt, ds_r, ds_nxt;
  logic [MAG_W-1:0] qn_r, qn_nxt, qd_r, qd_nxt;
  logic [MAG_W-1:0] rn_r, rn_nxt, rd_r, rd_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  logic [MAG_W:0]   shn, shd, difn, difd;
  logic             ge_n, ge_d;

  // One restoring step on the numerator and the denominator together.
  always_comb begin
    shn  = {rn_r, qn_r[MAG_W-1]};
    shd  = {rd_r, qd_r[MAG_W-1]};
    difn = shn - {1'b0, v_r};
    difd = shd - {1'b0, v_r};
    ge_n = (shn >= {1'b0, v_r});
    ge_d = (shd >= {1'b0, v_r});
  end

  always_comb begin
    phase_nxt = phase_r;
    done_nxt  = 1'b0;
    neg_nxt   = neg_r;
    u_nxt     = u_r;
    v_nxt     = v_r;
    ns_nxt    = ns_r;
    ds_nxt    = ds_r;
    qn_nxt    = qn_r;
    qd_nxt    = qd_r;
    rn_nxt    = rn_r;
    rd_nxt    = rd_r;
    cnt_nxt   = cnt_r;
    if (start) begin
      phase_nxt = RP_GCD;
      neg_nxt   = neg_i;
      u_nxt     = num_i;
      v_nxt     = den_i;
      ns_nxt    = num_i;
      ds_nxt    = den_i;
    end else begin
      unique case (phase_r)
        RP_IDLE: begin
        end
        RP_GCD: begin
          if (u_r == '0) begin
            // The gcd is v shifted by the common factors of two, which have
            // already been taken out of both dividends.
            phase_nxt = RP_DIV;
            cnt_nxt   = '0;
            qn_nxt    = ns_r;
            qd_nxt    = ds_r;
            rn_nxt    = '0;
            rd_nxt    = '0;
          end else if (!u_r[0] && !v_r[0]) begin
            u_nxt  = u_r >> 1;
            v_nxt  = v_r >> 1;
            ns_nxt = ns_r >> 1;
            ds_nxt = ds_r >> 1;
          end else if (!u_r[0]) begin
            u_nxt = u_r >> 1;
          end else if (!v_r[0]) begin
            v_nxt = v_r >> 1;
          end else if (u_r >= v_r) begin
            u_nxt = u_r - v_r;
          end else begin
            v_nxt = v_r - u_r;
          end
        end
        RP_DIV: begin
          rn_nxt  = ge_n ? difn[MAG_W-1:0] : shn[MAG_W-1:0];
          rd_nxt  = ge_d ? difd[MAG_W-1:0] : shd[MAG_W-1:0];
          qn_nxt  = {qn_r[MAG_W-2:0], ge_n};
          qd_nxt  = {qd_r[MAG_W-2:0], ge_d};
          cnt_nxt = cnt_r + 1'b1;
          if (cnt_r == CNT_W'(MAG_W - 1)) begin
            phase_nxt = RP_IDLE;
            done_nxt  = 1'b1;
          end
        end
        default: phase_nxt = RP_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= RP_IDLE;
      done_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    neg_r <= neg_nxt;
    u_r   <= u_nxt;
    v_r   <= v_nxt;
    ns_r  <= ns_nxt;
    ds_r  <= ds_nxt;
    qn_r  <= qn_nxt;
    qd_r  <= qd_nxt;
    rn_r  <= rn_nxt;
    rd_r  <= rd_nxt;
    cnt_r <= cnt_nxt;
  end

  assign done    = done_r;
  assign neg_o   = neg_r;
  assign quo_num = qn_r;
  assign quo_den = qd_r;

endmodule

>>> design/rau_datapath.sv
// Datapath: operand registers, shared multiplier, reduction unit and result register.
module rau_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  rau_pkg::in_item_t  in_item,
  input  rau_pkg::dp_ctrl_t  ctrl,
  output rau_pkg::dp_stat_t  stat,
  input  logic               out_stall,
  output logic               out_valid,
  output rau_pkg::out_item_t out_item
);
  import rau_pkg::*;

  in_item_t                 in_r;
  logic signed [OPR_W-1:0]  an_r, ad_r, bn_r, bd_r;
  logic signed [PROD_W-1:0] p0_r, p1_r, p2_r;
  out_item_t                out_r;
  logic                     out_valid_r;

  logic signed [PROD_W-1:0] red_n, red_d, abs_n, abs_d, sum;
  logic signed [OPR_W-1:0]  mul_x, mul_y;
  logic signed [PROD_W-1:0] prod;
  logic                     red_start, red_done, red_neg;
  logic [MAG_W-1:0]         quo_num, quo_den;
  logic signed [MAG_W:0]    quo_mag, quo_val;
  logic                     flag;
  logic                     out_free;

  always_comb begin
    unique case (in_r.command)
      CMD_ADD: sum = p0_r + p1_r;
      CMD_SUB: sum = p0_r - p1_r;
      default: sum = p0_r;
    endcase
  end

  always_comb begin
    unique case (ctrl.op)
      DP_RED_A: begin
        red_n = PROD_W'(in_r.a_num);
        red_d = PROD_W'(in_r.a_den);
      end
      DP_RED_B: begin
        red_n = PROD_W'(in_r.b_num);
        red_d = PROD_W'(in_r.b_den);
      end
      default: begin
        red_n = sum;
        red_d = p2_r;
      end
    endcase
    abs_n     = red_n[PROD_W-1] ? -red_n : red_n;
    abs_d     = red_d[PROD_W-1] ? -red_d : red_d;
    red_start = (ctrl.op == DP_RED_A) || (ctrl.op == DP_RED_B) || (ctrl.op == DP_RED_R);
  end

  rau_reduce u_reduce (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (red_start),
    .neg_i   (red_n[PROD_W-1] ^ red_d[PROD_W-1]),
    .num_i   (abs_n[MAG_W-1:0]),
    .den_i   (abs_d[MAG_W-1:0]),
    .done    (red_done),
    .neg_o   (red_neg),
    .quo_num (quo_num),
    .quo_den (quo_den)
  );

  assign quo_mag = $signed({1'b0, quo_num});
  assign quo_val = red_neg ? -quo_mag : quo_mag;

  // The cross products needed by each command, one per cycle.
  always_comb begin
    unique case (ctrl.op)
      DP_MUL0: begin
        mul_x = an_r;
        mul_y = (in_r.command == CMD_MUL) ? bn_r : bd_r;
      end
      DP_MUL1: begin
        mul_x = bn_r;
        mul_y = ad_r;
      end
      default: begin
        mul_x = ad_r;
        mul_y = (in_r.command == CMD_DIV) ? bn_r : bd_r;
      end
    endcase
    prod = mul_x * mul_y;
  end

  always_comb begin
    unique case (in_r.command)
      CMD_LT:  flag = (p0_r < p1_r);
      CMD_EQ:  flag = (an_r == bn_r) && (ad_r == bd_r);
      default: flag = 1'b0;
    endcase
  end

  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    unique case (ctrl.op)
      DP_LOAD:   in_r <= in_item;
      DP_SAVE_A: begin
        an_r <= OPR_W'(quo_val);
        ad_r <= OPR_W'($signed({1'b0, quo_den}));
      end
      DP_SAVE_B: begin
        bn_r <= OPR_W'(quo_val);
        bd_r <= OPR_W'($signed({1'b0, quo_den}));
      end
      DP_MUL0:   p0_r <= prod;
      DP_MUL1:   p1_r <= prod;
      DP_MUL2:   p2_r <= prod;
      DP_WR_RED: begin
        out_r.res_num <= RES_NUM_W'(quo_val);
        out_r.res_den <= RES_DEN_W'(quo_den);
        out_r.flag    <= 1'b0;
        out_r.status  <= 1'b0;
      end
      DP_WR_FLAG: begin
        out_r.res_num <= '0;
        out_r.res_den <= RES_DEN_W'(1);
        out_r.flag    <= flag;
        out_r.status  <= 1'b0;
      end
      DP_WR_ERR: begin
        out_r.res_num <= '0;
        out_r.res_den <= RES_DEN_W'(1);
        out_r.flag    <= 1'b0;
        out_r.status  <= 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((ctrl.op == DP_WR_RED) || (ctrl.op == DP_WR_FLAG) ||
                 (ctrl.op == DP_WR_ERR)) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign stat.den_zero  = (in_r.a_den == '0) || (in_r.b_den == '0);
  assign stat.bnum_zero = (bn_r == '0);
  assign stat.red_done  = red_done;
  assign stat.out_free  = out_free;
  assign stat.cmd       = in_r.command;

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

>>> design/rau_ctrl.sv
// Controller: sequences operand reduction, products and result reduction.
module rau_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  rau_pkg::dp_stat_t stat,
  output rau_pkg::dp_ctrl_t ctrl
);
  import rau_pkg::*;

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ctrl.op   = DP_NOP;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          ctrl.op   = DP_LOAD;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK:  state_nxt = stat.den_zero ? ST_OUT_ERR : ST_RED_A;
      ST_RED_A: begin
        ctrl.op   = DP_RED_A;
        state_nxt = ST_WAIT_A;
      end
      ST_WAIT_A: begin
        if (stat.red_done) begin
          ctrl.op   = DP_SAVE_A;
          state_nxt = ST_RED_B;
        end
      end
      ST_RED_B: begin
        ctrl.op   = DP_RED_B;
        state_nxt = ST_WAIT_B;
      end
      ST_WAIT_B: begin
        if (stat.red_done) begin
          ctrl.op   = DP_SAVE_B;
          state_nxt = ST_MUL0;
        end
      end
      ST_MUL0: begin
        ctrl.op   = DP_MUL0;
        state_nxt = ST_MUL1;
      end
      ST_MUL1: begin
        ctrl.op   = DP_MUL1;
        state_nxt = ST_MUL2;
      end
      ST_MUL2: begin
        ctrl.op   = DP_MUL2;
        state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        unique case (stat.cmd) inside
          CMD_ADD, CMD_SUB, CMD_MUL: state_nxt = ST_RED_R;
          CMD_DIV:                   state_nxt = stat.bnum_zero ? ST_OUT_ERR : ST_RED_R;
          default:                   state_nxt = ST_OUT_FLAG;
        endcase
      end
      ST_RED_R: begin
        ctrl.op   = DP_RED_R;
        state_nxt = ST_WAIT_R;
      end
      ST_WAIT_R: begin
        if (stat.red_done) begin
          state_nxt = ST_OUT_RED;
        end
      end
      ST_OUT_RED: begin
        if (stat.out_free) begin
          ctrl.op   = DP_WR_RED;
          state_nxt = ST_IDLE;
        end
      end
      ST_OUT_FLAG: begin
        if (stat.out_free) begin
          ctrl.op   = DP_WR_FLAG;
          state_nxt = ST_IDLE;
        end
      end
      ST_OUT_ERR: begin
        if (stat.out_free) begin
          ctrl.op   = DP_WR_ERR;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign in_stall = (state_r != ST_IDLE);

endmodule

>>> design/rational_arithmetic_unit.sv
// Top level of the rational arithmetic unit: controller and datapath.
// Usage:
// An input transfer carries a command and two signed fractions. Each operand
// is brought to lowest terms with a positive denominator, the command is
// applied, and one result transfer follows with the reduced fraction, a
// compare flag and an error status (zero denominator or division by zero).
// Items are processed one at a time: in_stall is high from the cycle after
// an input transfer until the result has been written to the output register.
// A zero denominator gives the error result without any reduction. Otherwise
// each operand passes through the reduction unit, and for add, subtract,
// multiply and divide by a nonzero value the result passes once more; the
// next item is accepted as soon as the result has been written.
// The result sits in an output register, so the next item is accepted while
// the receiver stalls; a finished item waits only while that register is full and the receiver stalls.
// Reset returns the controller to idle and empties the output register.
module rational_arithmetic_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  rau_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output rau_pkg::out_item_t out_item
);
  import rau_pkg::*;

  dp_ctrl_t ctrl;
  dp_stat_t stat;

  rau_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  rau_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .ctrl      (ctrl),
    .stat      (stat),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule
